// ===== rtl/fsk_delay_multiply_uart_demod_top_assert.svh =====
// assertion macros used by the demodulator back end
// both expect signals named clk and rst in the module that uses them
`ifndef FSK_DELAY_MULTIPLY_UART_DEMOD_TOP_ASSERT_SVH
`define FSK_DELAY_MULTIPLY_UART_DEMOD_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define FDMU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition in one cycle implies another in the next
`define FDMU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/fdmu_pkg.sv =====
`timescale 1ns / 1ps
package fdmu_pkg;

  localparam int ADC_W   = 12;
  localparam int SAMP_W  = 13;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 26;
  localparam int TERM_W  = 42;
  localparam int FILT_W  = 44;
  localparam int SUM_W   = 46;
  localparam int THR_W   = 41;
  localparam int ZC_W    = 4;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 41;
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ADC_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ZEROS = 2'd2;

  localparam logic [ADC_W-1:0]        OFFSET_RST = 12'd2048;
  localparam logic signed [THR_W-1:0] THR_RST    = 41'sd32768;
  localparam logic [ZC_W-1:0]         ZEROS_RST  = 4'd4;

  localparam int COEF_HALF = 10;
  // q15 low-pass taps, outer tap first, center tap last
  localparam logic signed [COEF_W-1:0] COEF_Q15 [COEF_HALF] = '{
    16'sd257, 16'sd614, 16'sd171, -16'sd621, -16'sd1532,
    -16'sd1233, 16'sd973, 16'sd4730, 16'sd8324, 16'sd9814
  };

  typedef logic signed [FILT_W-1:0] filt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // symmetric tap lookup, taps with no listed value are zero
  function automatic logic signed [COEF_W-1:0] tap_coef(input int unsigned i,
                                                        input int unsigned taps);
    int unsigned m;
    int unsigned k;
    logic signed [COEF_W-1:0] c;
    m = taps - 1 - i;
    k = (i < m) ? i : m;
    c = '0;
    if (k < COEF_HALF) c = COEF_Q15[k[3:0]];
    return c;
  endfunction

endpackage

// ===== rtl/fsk_delay_multiply_uart_demod_top.sv =====
`timescale 1ns / 1ps
// fsk delay-and-multiply demodulator with uart-style framing
// sample channel: one raw 12-bit converter sample per transfer (sample_valid / sample_stall)
// result channel: one received_byte per complete frame (result_valid / result_stall)
// config port: cfg_we with cfg_index 0 adc offset, 1 decision threshold, 2 start zero count
//   write only while no sample is in flight
// sample_stall is high from each accepted sample until its filter output enters the queue,
//   while the shared multiply-accumulate walks the filter taps over the sample history
// the front end hands each filter output to a two-entry queue; the slicer takes one output
//   per cycle while the queue is not empty until its bit window is full, then runs B_SUM and
//   B_DECIDE for a bit decision, and registers received_byte with result_valid on a frame's last bit
// a finished byte waits in the output register while result_stall is high; the front end
//   keeps taking samples until the queue fills, then holds sample_stall
// reset: history reads as zero, slicer idle hunting for start zeros, registers at defaults
module fsk_delay_multiply_uart_demod_top #(
  parameter int DELAY_TAPS      = 5,
  parameter int FILTER_TAPS     = 19,
  parameter int SAMPLES_PER_BIT = 10,
  parameter int FRAME_BITS      = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [fdmu_pkg::ADC_W-1:0]          sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [fdmu_pkg::BYTE_W-1:0]         received_byte,
  input  logic                                cfg_we,
  input  logic [fdmu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdmu_pkg::CFG_W-1:0]          cfg_data
);
  import fdmu_pkg::*;

  logic [ADC_W-1:0]        adc_offset;
  logic signed [THR_W-1:0] decision_threshold;
  logic [ZC_W-1:0]         start_zeros_needed;

  logic    q_push;
  logic    q_pop;
  filt_t   q_din;
  filt_t   q_dout;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset         <= OFFSET_RST;
      decision_threshold <= THR_RST;
      start_zeros_needed <= ZEROS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADC_OFFSET:  adc_offset         <= cfg_data[ADC_W-1:0];
        CFG_THRESHOLD:   decision_threshold <= $signed(cfg_data[THR_W-1:0]);
        CFG_START_ZEROS: start_zeros_needed <= cfg_data[ZC_W-1:0];
        default: ;
      endcase
    end
  end

  fdmu_front #(
    .DELAY_TAPS  (DELAY_TAPS),
    .FILTER_TAPS (FILTER_TAPS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .adc_offset   (adc_offset),
    .q_push       (q_push),
    .q_data       (q_din),
    .q_stat       (q_stat)
  );

  fdmu_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  fdmu_back #(
    .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
    .FRAME_BITS      (FRAME_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_stat             (q_stat),
    .q_data             (q_dout),
    .q_pop              (q_pop),
    .decision_threshold (decision_threshold),
    .start_zeros_needed (start_zeros_needed),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .received_byte      (received_byte)
  );

endmodule

// ===== rtl/fdmu_fifo.sv =====
`timescale 1ns / 1ps
module fdmu_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fdmu_pkg::filt_t din,
  input  logic            pop,
  output fdmu_pkg::filt_t dout,
  output fdmu_pkg::q_stat_t stat
);
  import fdmu_pkg::*;

  localparam int QP_W = $clog2(Q_DEPTH);

  filt_t             mem [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QP_W:0]     count;

  assign stat.full  = (count == (QP_W+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !stat.full) mem[wr_ptr] <= din;
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !stat.full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !stat.empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !stat.full, pop && !stat.empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/fdmu_front.sv =====
`timescale 1ns / 1ps
module fdmu_front #(
  parameter int DELAY_TAPS  = 5,
  parameter int FILTER_TAPS = 19
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [fdmu_pkg::ADC_W-1:0]   sample,
  input  logic [fdmu_pkg::ADC_W-1:0]   adc_offset,
  output logic                         q_push,
  output fdmu_pkg::filt_t              q_data,
  input  fdmu_pkg::q_stat_t            q_stat
);
  import fdmu_pkg::*;

  localparam int HIST_LEN = DELAY_TAPS + FILTER_TAPS;
  localparam int PTR_W    = $clog2(HIST_LEN);
  localparam int TAP_W    = $clog2(FILTER_TAPS);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_RUN   = 2'd1;
  localparam logic [1:0] F_DRAIN = 2'd2;

  logic [1:0]                state;
  logic signed [SAMP_W-1:0]  hist_mem [HIST_LEN];
  logic [HIST_LEN-1:0]       hist_ok;
  logic [PTR_W-1:0]          wp;
  logic [PTR_W-1:0]          ra;
  logic [PTR_W-1:0]          rb;
  logic [TAP_W-1:0]          tap;
  logic [TAP_W-1:0]          k1;
  logic [TAP_W-1:0]          k2;
  logic                      v1, v2, v3;
  logic                      va, vb;
  logic signed [SAMP_W-1:0]  rd_a, rd_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  term;
  filt_t                     acc;

  logic                      accept;
  logic signed [SAMP_W-1:0]  diff;
  logic signed [SAMP_W-1:0]  a_m, b_m;
  logic [PTR_W-1:0]          wp_inc, ra_inc, rb_inc, rb0;
  logic [PTR_W:0]            rb_sum, rb_wrap;
  logic                      pipe_empty;

  assign sample_stall = (state != F_IDLE);
  assign accept       = sample_valid && (state == F_IDLE);
  assign diff         = $signed({1'b0, sample}) - $signed({1'b0, adc_offset});

  assign wp_inc = (wp == PTR_W'(HIST_LEN - 1)) ? '0 : wp + 1'b1;
  assign ra_inc = (ra == PTR_W'(HIST_LEN - 1)) ? '0 : ra + 1'b1;
  assign rb_inc = (rb == PTR_W'(HIST_LEN - 1)) ? '0 : rb + 1'b1;

  // delayed read starts DELAY_TAPS entries after the oldest one
  assign rb_sum  = (PTR_W+1)'(wp_inc) + (PTR_W+1)'(DELAY_TAPS);
  assign rb_wrap = (rb_sum >= (PTR_W+1)'(HIST_LEN)) ? rb_sum - (PTR_W+1)'(HIST_LEN) : rb_sum;
  assign rb0     = rb_wrap[PTR_W-1:0];

  // entries never written since reset read as zero
  assign a_m = va ? rd_a : '0;
  assign b_m = vb ? rd_b : '0;

  assign pipe_empty = !v1 && !v2 && !v3;
  assign q_push     = (state == F_DRAIN) && pipe_empty && !q_stat.full;
  assign q_data     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      hist_ok <= '0;
      wp      <= '0;
      ra      <= '0;
      rb      <= '0;
      tap     <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
    end else begin
      v1 <= (state == F_RUN);
      v2 <= v1;
      v3 <= v2;
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            hist_ok[wp] <= 1'b1;
            wp          <= wp_inc;
            ra          <= wp_inc;
            rb          <= rb0;
            tap         <= '0;
            state       <= F_RUN;
          end
        end
        F_RUN: begin
          ra  <= ra_inc;
          rb  <= rb_inc;
          tap <= tap + 1'b1;
          if (tap == TAP_W'(FILTER_TAPS - 1)) state <= F_DRAIN;
        end
        F_DRAIN: begin
          if (pipe_empty && !q_stat.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // read, delay product, coefficient product, accumulate
  always_ff @(posedge clk) begin
    if (accept) hist_mem[wp] <= diff;
    rd_a <= hist_mem[ra];
    rd_b <= hist_mem[rb];
    va   <= hist_ok[ra];
    vb   <= hist_ok[rb];
    k1   <= tap;
    k2   <= k1;
    prod <= PROD_W'(a_m) * PROD_W'(b_m);
    term <= TERM_W'(tap_coef(32'(k2), FILTER_TAPS)) * TERM_W'(prod);
    if (state == F_IDLE) acc <= '0;
    else if (v3)         acc <= acc + FILT_W'(term);
  end

endmodule

// ===== rtl/fdmu_back.sv =====
`timescale 1ns / 1ps
module fdmu_back #(
  parameter int SAMPLES_PER_BIT = 10,
  parameter int FRAME_BITS      = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fdmu_pkg::q_stat_t                 q_stat,
  input  fdmu_pkg::filt_t                   q_data,
  output logic                              q_pop,
  input  logic signed [fdmu_pkg::THR_W-1:0] decision_threshold,
  input  logic [fdmu_pkg::ZC_W-1:0]         start_zeros_needed,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [fdmu_pkg::BYTE_W-1:0]       received_byte
);
  import fdmu_pkg::*;
  `include "fsk_delay_multiply_uart_demod_top_assert.svh"

  localparam int PH_W = $clog2(SAMPLES_PER_BIT);
  localparam int FB_W = $clog2(FRAME_BITS);
  localparam int MID  = SAMPLES_PER_BIT / 2;

  localparam logic [1:0] B_TAKE   = 2'd0;
  localparam logic [1:0] B_SUM    = 2'd1;
  localparam logic [1:0] B_DECIDE = 2'd2;

  logic [1:0]               state;
  filt_t                    fh [SAMPLES_PER_BIT];
  logic [PH_W-1:0]          ph;
  logic                     idle;
  logic [ZC_W-1:0]          zc;
  logic [FRAME_BITS-1:0]    fs;
  logic [FB_W-1:0]          fbc;
  logic signed [SUM_W-1:0]  sum3;

  logic                     bit_one;
  logic                     go;
  logic [ZC_W-1:0]          zc_inc;
  logic                     start;
  logic                     in_frame;
  logic                     last;
  logic                     decide;
  logic                     emit;
  logic [FRAME_BITS-1:0]    fs_new;

  assign q_pop   = (state == B_TAKE) && !q_stat.empty;
  assign bit_one = sum3 < SUM_W'(decision_threshold);
  assign go      = !result_valid || !result_stall;
  assign decide  = (state == B_DECIDE) && go;
  assign zc_inc  = zc + 1'b1;
  // a zero requirement behaves like one since the count is never below zero
  assign start    = idle && !bit_one && (zc_inc >= start_zeros_needed);
  assign in_frame = !idle || start;
  assign last     = in_frame && (fbc == FB_W'(FRAME_BITS - 1));
  assign emit     = decide && last;

  always_comb begin
    fs_new      = fs;
    fs_new[fbc] = bit_one;
  end

  always_ff @(posedge clk) begin
    if (q_pop) fh[ph] <= q_data;
    if (decide && !in_frame) begin
      for (int i = 0; i < SAMPLES_PER_BIT - 1; i++) fh[i] <= fh[i+1];
    end
    if (state == B_SUM)
      sum3 <= SUM_W'(fh[MID-1]) + SUM_W'(fh[MID]) + SUM_W'(fh[MID+1]);
    if (decide && in_frame) fs <= fs_new;
    if (emit) received_byte <= fs_new[BYTE_W:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_TAKE;
      ph           <= '0;
      idle         <= 1'b1;
      zc           <= '0;
      fbc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      unique case (state)
        B_TAKE: begin
          if (q_pop) begin
            if (ph == PH_W'(SAMPLES_PER_BIT - 1)) state <= B_SUM;
            else                                  ph    <= ph + 1'b1;
          end
        end
        B_SUM: state <= B_DECIDE;
        B_DECIDE: begin
          if (go) begin
            state <= B_TAKE;
            if (in_frame) begin
              ph <= '0;
              zc <= '0;
              if (last) begin
                fbc          <= '0;
                idle         <= 1'b1;
                result_valid <= 1'b1;
              end else begin
                fbc  <= fbc + 1'b1;
                idle <= 1'b0;
              end
            end else begin
              // no start yet: slide the window one sample
              zc <= bit_one ? '0 : zc_inc;
              ph <= PH_W'(SAMPLES_PER_BIT - 1);
            end
          end
        end
        default: state <= B_TAKE;
      endcase
    end
  end

  `FDMU_ASSERT(a_ph_range, 32'(ph) < SAMPLES_PER_BIT, "phase beyond bit period")
  `FDMU_ASSERT(a_fbc_range, 32'(fbc) < FRAME_BITS, "frame bit count overran")
  `FDMU_ASSERT(a_frame_zc, idle || (zc == '0), "start count not cleared in frame")
  `FDMU_ASSERT_NEXT(a_emit_idle, emit, idle && (fbc == '0) && (ph == '0) && result_valid, "byte emitted without frame reset")

endmodule
